// ===== src/asc_pkg.sv =====
// Shared types, character codes and character classes of the assembly token scanner.
package asc_pkg;

  localparam int unsigned CH_BITS   = 8;
  localparam int unsigned KIND_BITS = 3;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_END     = 3'd0,
    KIND_INT     = 3'd1,
    KIND_LABEL   = 3'd2,
    KIND_REG     = 3'd3,
    KIND_IDENT   = 3'd4,
    KIND_ILLEGAL = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_MINUS   = 3'd2,
    MODE_NUMBER  = 3'd3,
    MODE_WORD    = 3'd4
  } mode_e;

  localparam logic [CH_BITS-1:0] CH_NUL        = 8'h00;
  localparam logic [CH_BITS-1:0] CH_TAB        = 8'h09;
  localparam logic [CH_BITS-1:0] CH_LF         = 8'h0A;
  localparam logic [CH_BITS-1:0] CH_CR         = 8'h0D;
  localparam logic [CH_BITS-1:0] CH_SPACE      = 8'h20;
  localparam logic [CH_BITS-1:0] CH_COMMA      = 8'h2C;
  localparam logic [CH_BITS-1:0] CH_MINUS      = 8'h2D;
  localparam logic [CH_BITS-1:0] CH_ZERO       = 8'h30;
  localparam logic [CH_BITS-1:0] CH_NINE       = 8'h39;
  localparam logic [CH_BITS-1:0] CH_COLON      = 8'h3A;
  localparam logic [CH_BITS-1:0] CH_SEMI       = 8'h3B;
  localparam logic [CH_BITS-1:0] CH_UPPER_A    = 8'h41;
  localparam logic [CH_BITS-1:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [CH_BITS-1:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [CH_BITS-1:0] CH_LOWER_A    = 8'h61;
  localparam logic [CH_BITS-1:0] CH_LOWER_R    = 8'h72;
  localparam logic [CH_BITS-1:0] CH_LOWER_Z    = 8'h7A;

  function automatic logic is_digit(input logic [CH_BITS-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(input logic [CH_BITS-1:0] c);
    return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
           ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
  endfunction

  function automatic logic is_word(input logic [CH_BITS-1:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE);
  endfunction

  function automatic logic is_blank(input logic [CH_BITS-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

// ===== src/asc_fifo.sv =====
// Result queue of four entries that takes up to two entries and gives one per cycle while the reader takes them.
module asc_fifo #(
  parameter int unsigned WIDTH = 84
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_cnt_i,
  input  logic [WIDTH-1:0] push0_i,
  input  logic [WIDTH-1:0] push1_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             valid_o,
  output logic             room_o
);

  localparam int unsigned DEPTH    = 4;
  localparam int unsigned PTR_BITS = $clog2(DEPTH);
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_next;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                pop;

  assign pop     = pop_i && (cnt_q != '0);
  assign wr_next = PTR_BITS'(wr_ptr_q + 1'b1);
  assign data_o  = mem_q[rd_ptr_q];
  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= CNT_BITS'(DEPTH - 2));

  always_comb begin
    wr_ptr_d = PTR_BITS'(wr_ptr_q + PTR_BITS'(push_cnt_i));
    rd_ptr_d = pop ? PTR_BITS'(rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = CNT_BITS'(cnt_q + CNT_BITS'(push_cnt_i) - CNT_BITS'(pop));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_next] <= push1_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_BITS'(DEPTH))
    else $error("Result queue holds more entries than it has.");

  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt_i != 2'd0) |-> room_o)
    else $error("Results were pushed without room for two entries.");

endmodule

// ===== src/asc_core.sv =====
// Scanner state and the per-byte decode that turns one byte into up to two results.
module asc_core #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned POS_BITS   = 16,
  parameter int unsigned LEN_BITS   = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic [asc_pkg::CH_BITS-1:0]        ch_i,
  output logic [1:0]                         count_o,
  output logic [((2*POS_BITS+LEN_BITS+VALUE_BITS+1+7)/8)*8+asc_pkg::KIND_BITS:0] entry0_o,
  output logic [((2*POS_BITS+LEN_BITS+VALUE_BITS+1+7)/8)*8+asc_pkg::KIND_BITS:0] entry1_o
);

  localparam int unsigned FIELD_BITS = 2*POS_BITS + LEN_BITS + VALUE_BITS + 1;
  localparam int unsigned DATA_BITS  = ((FIELD_BITS + 7) / 8) * 8;
  localparam int unsigned ENTRY_BITS = DATA_BITS + asc_pkg::KIND_BITS + 1;
  localparam logic [VALUE_BITS-1:0] HALF    = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] HALF_M1 = {1'b0, {(VALUE_BITS-1){1'b1}}};

  asc_pkg::mode_e        mode_q, mode_d;
  logic [POS_BITS-1:0]   line_q, line_d, col_q, col_d;
  logic [POS_BITS-1:0]   tok_line_q, tok_line_d, tok_col_q, tok_col_d;
  logic [LEN_BITS-1:0]   tok_len_q, tok_len_d, len_grown;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic                  neg_q, neg_d, sat_q, sat_d, sr_q, sr_d, ract_q, ract_d;

  logic [3:0]            digit;
  logic [VALUE_BITS-1:0] cap, acc_next, num_val;
  logic [VALUE_BITS+3:0] scaled;
  logic                  dig_sat, num_oor;
  logic                  is_dig, flush, rescan, idle_emit;
  asc_pkg::kind_e        fl_kind, id_kind;
  logic [LEN_BITS-1:0]   fl_len;
  logic [VALUE_BITS-1:0] fl_val;
  logic                  fl_oor;

  function automatic logic [ENTRY_BITS-1:0] pack(
    input logic                  last,
    input asc_pkg::kind_e        kind,
    input logic [POS_BITS-1:0]   line,
    input logic [POS_BITS-1:0]   col,
    input logic [LEN_BITS-1:0]   len,
    input logic [VALUE_BITS-1:0] val,
    input logic                  oor
  );
    logic [DATA_BITS-1:0] data;
    data = DATA_BITS'({oor, val, len, col, line});
    return {last, kind, data};
  endfunction

  // Shared decimal accumulate: value times ten plus digit, clamped at the cap.
  assign is_dig   = asc_pkg::is_digit(ch_i);
  assign digit    = 4'(ch_i - asc_pkg::CH_ZERO);
  assign cap      = (mode_q == asc_pkg::MODE_WORD) ? HALF_M1 : HALF;
  assign scaled   = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + (VALUE_BITS+4)'(digit);
  assign dig_sat  = (acc_q > cap) || (scaled > {4'b0, cap});
  assign acc_next = dig_sat ? cap : scaled[VALUE_BITS-1:0];

  assign num_val  = neg_q ? VALUE_BITS'(~acc_q + 1'b1) : ((acc_q > HALF_M1) ? HALF_M1 : acc_q);
  assign num_oor  = neg_q ? sat_q : (sat_q || (acc_q > HALF_M1));
  assign len_grown = (tok_len_q == '1) ? tok_len_q : LEN_BITS'(tok_len_q + 1'b1);

  always_comb begin
    mode_d     = mode_q;
    tok_line_d = tok_line_q;
    tok_col_d  = tok_col_q;
    tok_len_d  = tok_len_q;
    acc_d      = acc_q;
    neg_d      = neg_q;
    sat_d      = sat_q;
    sr_d       = sr_q;
    ract_d     = ract_q;
    flush      = 1'b0;
    rescan     = 1'b0;
    idle_emit  = 1'b0;
    fl_kind    = asc_pkg::KIND_INT;
    fl_len     = tok_len_q;
    fl_val     = '0;
    fl_oor     = 1'b0;
    id_kind    = asc_pkg::KIND_END;

    unique case (mode_q)
      asc_pkg::MODE_COMMENT: begin
        if (ch_i == asc_pkg::CH_NUL) begin
          rescan = 1'b1;
        end else if (ch_i == asc_pkg::CH_LF) begin
          mode_d = asc_pkg::MODE_IDLE;
        end
      end
      asc_pkg::MODE_MINUS: begin
        if (is_dig) begin
          neg_d     = 1'b1;
          tok_len_d = len_grown;
          acc_d     = acc_next;
          sat_d     = sat_q || dig_sat;
          mode_d    = asc_pkg::MODE_NUMBER;
        end else begin
          flush   = 1'b1;
          fl_kind = asc_pkg::KIND_ILLEGAL;
          fl_len  = '0;
          rescan  = 1'b1;
        end
      end
      asc_pkg::MODE_NUMBER: begin
        if (is_dig) begin
          tok_len_d = len_grown;
          acc_d     = acc_next;
          sat_d     = sat_q || dig_sat;
        end else begin
          flush   = 1'b1;
          fl_kind = asc_pkg::KIND_INT;
          fl_val  = num_val;
          fl_oor  = num_oor;
          rescan  = 1'b1;
        end
      end
      asc_pkg::MODE_WORD: begin
        if (asc_pkg::is_word(ch_i)) begin
          tok_len_d = len_grown;
          if (ract_q && is_dig) begin
            acc_d = acc_next;
            sat_d = sat_q || dig_sat;
          end else begin
            ract_d = 1'b0;
          end
        end else if (ch_i == asc_pkg::CH_COLON) begin
          flush   = 1'b1;
          fl_kind = asc_pkg::KIND_LABEL;
          mode_d  = asc_pkg::MODE_IDLE;
        end else begin
          flush  = 1'b1;
          rescan = 1'b1;
          if (sr_q) begin
            fl_kind = asc_pkg::KIND_REG;
            fl_val  = acc_q;
            fl_oor  = sat_q;
          end else begin
            fl_kind = asc_pkg::KIND_IDENT;
          end
        end
      end
      default: begin
        rescan = 1'b1;
      end
    endcase

    if (rescan) begin
      mode_d = asc_pkg::MODE_IDLE;
      priority if (ch_i == asc_pkg::CH_NUL) begin
        idle_emit = 1'b1;
        id_kind   = asc_pkg::KIND_END;
      end else if (asc_pkg::is_blank(ch_i) || (ch_i == asc_pkg::CH_COMMA)) begin
        mode_d = asc_pkg::MODE_IDLE;
      end else if (ch_i == asc_pkg::CH_SEMI) begin
        mode_d = asc_pkg::MODE_COMMENT;
      end else if (is_dig || (ch_i == asc_pkg::CH_MINUS) ||
                   asc_pkg::is_alpha(ch_i) || (ch_i == asc_pkg::CH_UNDERSCORE)) begin
        tok_line_d = line_q;
        tok_col_d  = col_q;
        tok_len_d  = LEN_BITS'(1);
        acc_d      = '0;
        neg_d      = 1'b0;
        sat_d      = 1'b0;
        sr_d       = 1'b0;
        ract_d     = 1'b0;
        if (is_dig) begin
          acc_d  = VALUE_BITS'(digit);
          mode_d = asc_pkg::MODE_NUMBER;
        end else if (ch_i == asc_pkg::CH_MINUS) begin
          mode_d = asc_pkg::MODE_MINUS;
        end else begin
          sr_d   = (ch_i == asc_pkg::CH_LOWER_R);
          ract_d = (ch_i == asc_pkg::CH_LOWER_R);
          mode_d = asc_pkg::MODE_WORD;
        end
      end else begin
        idle_emit = 1'b1;
        id_kind   = asc_pkg::KIND_ILLEGAL;
      end
    end
  end

  always_comb begin
    line_d = line_q;
    col_d  = col_q;
    if (ch_i != asc_pkg::CH_NUL) begin
      if (ch_i == asc_pkg::CH_LF) begin
        line_d = (line_q == '1) ? line_q : POS_BITS'(line_q + 1'b1);
        col_d  = POS_BITS'(1);
      end else begin
        col_d = (col_q == '1) ? col_q : POS_BITS'(col_q + 1'b1);
      end
    end
  end

  assign count_o  = {flush && idle_emit, flush ^ idle_emit};
  assign entry1_o = pack(1'b1, id_kind, line_q, col_q, '0, '0, 1'b0);
  assign entry0_o = flush ? pack(!idle_emit, fl_kind, tok_line_q, tok_col_q, fl_len, fl_val, fl_oor)
                          : entry1_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= asc_pkg::MODE_IDLE;
      line_q     <= POS_BITS'(1);
      col_q      <= POS_BITS'(1);
      tok_line_q <= POS_BITS'(1);
      tok_col_q  <= POS_BITS'(1);
      tok_len_q  <= '0;
      acc_q      <= '0;
      neg_q      <= 1'b0;
      sat_q      <= 1'b0;
      sr_q       <= 1'b0;
      ract_q     <= 1'b0;
    end else if (en_i) begin
      mode_q     <= mode_d;
      line_q     <= line_d;
      col_q      <= col_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
      tok_len_q  <= tok_len_d;
      acc_q      <= acc_d;
      neg_q      <= neg_d;
      sat_q      <= sat_d;
      sr_q       <= sr_d;
      ract_q     <= ract_d;
    end
  end

  a_open_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((mode_q == asc_pkg::MODE_MINUS) || (mode_q == asc_pkg::MODE_NUMBER) ||
     (mode_q == asc_pkg::MODE_WORD)) |-> (tok_len_q != '0))
    else $error("An open token has zero length.");

  a_reg_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sr_q |-> !ract_q)
    else $error("Register digits are collected for a word not starting with r.");

endmodule

// ===== src/assembly_token_scanner.sv =====
// Assembly token scanner: one source byte per item in, tokens out.
// The block takes one source byte per clock cycle and emits zero, one or two tokens per
// byte, since a token is only known to be complete at the byte that follows it. A byte is
// registered on entry, decoded from that register and its tokens are written into a
// four-entry result queue, whose head entry drives the output. Bytes are taken at one
// per cycle as long as the queue has room for two tokens; the rate is set by the result
// side, which gives one token per cycle while the output is ready. tlast marks the
// final token caused by one byte; a byte of zero ends the input and yields the end
// token.
module assembly_token_scanner #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned POS_BITS   = 16,
  parameter int unsigned LEN_BITS   = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // ch
  input  logic [asc_pkg::CH_BITS-1:0]           s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // start_line, start_column, token_length, token_value, out_of_range, zero fill
  output logic [((2*POS_BITS+LEN_BITS+VALUE_BITS+1+7)/8)*8-1:0] m_axis_tdata_o,
  // token_kind
  output logic [asc_pkg::KIND_BITS-1:0]         m_axis_tuser_o,
  output logic                                  m_axis_tlast_o
);

  localparam int unsigned FIELD_BITS = 2*POS_BITS + LEN_BITS + VALUE_BITS + 1;
  localparam int unsigned DATA_BITS  = ((FIELD_BITS + 7) / 8) * 8;
  localparam int unsigned ENTRY_BITS = DATA_BITS + asc_pkg::KIND_BITS + 1;

  logic                        in_vld_q, in_vld_d;
  logic [asc_pkg::CH_BITS-1:0] ch_q;
  logic                        fire, room;
  logic [1:0]                  core_cnt, push_cnt;
  logic [ENTRY_BITS-1:0]       entry0, entry1, head;

  assign fire            = in_vld_q && room;
  assign s_axis_tready_o = !in_vld_q || fire;
  assign in_vld_d        = s_axis_tready_o ? s_axis_tvalid_i : in_vld_q;
  assign push_cnt        = fire ? core_cnt : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      ch_q <= s_axis_tdata_i;
    end
  end

  asc_core #(
    .VALUE_BITS (VALUE_BITS),
    .POS_BITS   (POS_BITS),
    .LEN_BITS   (LEN_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (fire),
    .ch_i     (ch_q),
    .count_o  (core_cnt),
    .entry0_o (entry0),
    .entry1_o (entry1)
  );

  asc_fifo #(
    .WIDTH (ENTRY_BITS)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (entry0),
    .push1_i    (entry1),
    .pop_i      (m_axis_tready_i),
    .data_o     (head),
    .valid_o    (m_axis_tvalid_o),
    .room_o     (room)
  );

  assign m_axis_tdata_o = head[DATA_BITS-1:0];
  assign m_axis_tuser_o = head[DATA_BITS +: asc_pkg::KIND_BITS];
  assign m_axis_tlast_o = head[ENTRY_BITS-1];

  a_held_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !fire) |=> (in_vld_q && $stable(ch_q)))
    else $error("A waiting source byte was lost or changed.");

endmodule

// ===== tb/sv/assembly_token_scanner_tb.sv =====
// Self-checking testbench of the assembly token scanner, with a token predictor and scoreboard.
`timescale 1ns / 100ps

module assembly_token_scanner_tb;

  localparam int TDATA_W = 80;
  localparam logic [63:0] HALF = 64'h8000_0000;
  localparam logic [63:0] POS_MAX = 64'hFFFF;
  localparam logic [63:0] LEN_MAX = 64'hFF;

  typedef struct {
    asc_pkg::kind_e kind;
    logic [15:0]    line;
    logic [15:0]    col;
    logic [7:0]     len;
    logic [31:0]    value;
    logic           oor;
    logic           last;
  } token_t;

  class token_scoreboard;
    asc_pkg::mode_e mode;
    logic [63:0]    line_cnt, col_cnt, tok_line, tok_col, tok_len, accum;
    bit             neg, sat, r_start, r_digits;
    token_t         fresh[$];
    token_t         pending_tokens[$];
    int             errors;
    int             bytes_noted;
    int             seen[6];

    function new();
      mode = asc_pkg::MODE_IDLE;
      line_cnt = 64'd1;
      col_cnt = 64'd1;
      tok_line = 64'd1;
      tok_col = 64'd1;
      tok_len = 64'd0;
      accum = 64'd0;
      neg = 1'b0;
      sat = 1'b0;
      r_start = 1'b0;
      r_digits = 1'b0;
      errors = 0;
      bytes_noted = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function bit digit_ch(logic [7:0] c);
      return c >= asc_pkg::CH_ZERO && c <= asc_pkg::CH_NINE;
    endfunction

    function bit alpha_ch(logic [7:0] c);
      return (c >= asc_pkg::CH_LOWER_A && c <= asc_pkg::CH_LOWER_Z) ||
             (c >= asc_pkg::CH_UPPER_A && c <= asc_pkg::CH_UPPER_Z);
    endfunction

    function void step_pos(logic [7:0] c);
      if (c == asc_pkg::CH_LF) begin
        if (line_cnt < POS_MAX) line_cnt++;
        col_cnt = 64'd1;
      end else if (col_cnt < POS_MAX) begin
        col_cnt++;
      end
    endfunction

    function void grow_len();
      if (tok_len < LEN_MAX) tok_len++;
    endfunction

    function void add_digit(logic [7:0] c, logic [63:0] cap);
      logic [63:0] d;
      d = 64'(c - asc_pkg::CH_ZERO);
      if (accum > cap || accum > (cap - d) / 10) begin
        accum = cap;
        sat = 1'b1;
      end else begin
        accum = accum * 10 + d;
      end
    endfunction

    function void open_token();
      tok_line = line_cnt;
      tok_col = col_cnt;
      tok_len = 64'd1;
      accum = 64'd0;
      neg = 1'b0;
      sat = 1'b0;
      r_start = 1'b0;
      r_digits = 1'b0;
    endfunction

    function void emit_token(asc_pkg::kind_e kind, logic [63:0] line, logic [63:0] col,
                             logic [63:0] len, logic [63:0] value, bit oor);
      token_t tok;
      tok.kind = kind;
      tok.line = line[15:0];
      tok.col = col[15:0];
      tok.len = len[7:0];
      tok.value = value[31:0];
      tok.oor = oor;
      tok.last = 1'b0;
      fresh.push_back(tok);
    endfunction

    function void from_idle(logic [7:0] c);
      mode = asc_pkg::MODE_IDLE;
      if (c == asc_pkg::CH_NUL) begin
        emit_token(asc_pkg::KIND_END, line_cnt, col_cnt, 64'd0, 64'd0, 1'b0);
      end else if (c == asc_pkg::CH_SPACE || (c >= asc_pkg::CH_TAB && c <= asc_pkg::CH_CR) ||
                   c == asc_pkg::CH_COMMA) begin
        step_pos(c);
      end else if (c == asc_pkg::CH_SEMI) begin
        mode = asc_pkg::MODE_COMMENT;
        step_pos(c);
      end else if (digit_ch(c)) begin
        open_token();
        add_digit(c, HALF);
        mode = asc_pkg::MODE_NUMBER;
        step_pos(c);
      end else if (c == asc_pkg::CH_MINUS) begin
        open_token();
        mode = asc_pkg::MODE_MINUS;
        step_pos(c);
      end else if (alpha_ch(c) || c == asc_pkg::CH_UNDERSCORE) begin
        open_token();
        r_start = (c == asc_pkg::CH_LOWER_R);
        r_digits = r_start;
        mode = asc_pkg::MODE_WORD;
        step_pos(c);
      end else begin
        emit_token(asc_pkg::KIND_ILLEGAL, line_cnt, col_cnt, 64'd0, 64'd0, 1'b0);
        step_pos(c);
      end
    endfunction

    function void note_byte(logic [7:0] c);
      token_t tok;
      fresh.delete();
      unique case (mode)
        asc_pkg::MODE_COMMENT: begin
          if (c == asc_pkg::CH_NUL) begin
            from_idle(c);
          end else begin
            if (c == asc_pkg::CH_LF) mode = asc_pkg::MODE_IDLE;
            step_pos(c);
          end
        end
        asc_pkg::MODE_MINUS: begin
          if (digit_ch(c)) begin
            neg = 1'b1;
            grow_len();
            add_digit(c, HALF);
            mode = asc_pkg::MODE_NUMBER;
            step_pos(c);
          end else begin
            emit_token(asc_pkg::KIND_ILLEGAL, tok_line, tok_col, 64'd0, 64'd0, 1'b0);
            from_idle(c);
          end
        end
        asc_pkg::MODE_NUMBER: begin
          if (digit_ch(c)) begin
            grow_len();
            add_digit(c, HALF);
            step_pos(c);
          end else begin
            if (neg)
              emit_token(asc_pkg::KIND_INT, tok_line, tok_col, tok_len, 64'd0 - accum, sat);
            else if (accum > HALF - 1)
              emit_token(asc_pkg::KIND_INT, tok_line, tok_col, tok_len, HALF - 1, 1'b1);
            else
              emit_token(asc_pkg::KIND_INT, tok_line, tok_col, tok_len, accum, sat);
            from_idle(c);
          end
        end
        asc_pkg::MODE_WORD: begin
          if (digit_ch(c) || alpha_ch(c) || c == asc_pkg::CH_UNDERSCORE) begin
            grow_len();
            if (r_digits && digit_ch(c)) add_digit(c, HALF - 1);
            else r_digits = 1'b0;
            step_pos(c);
          end else if (c == asc_pkg::CH_COLON) begin
            emit_token(asc_pkg::KIND_LABEL, tok_line, tok_col, tok_len, 64'd0, 1'b0);
            mode = asc_pkg::MODE_IDLE;
            step_pos(c);
          end else begin
            if (r_start)
              emit_token(asc_pkg::KIND_REG, tok_line, tok_col, tok_len, accum, sat);
            else
              emit_token(asc_pkg::KIND_IDENT, tok_line, tok_col, tok_len, 64'd0, 1'b0);
            from_idle(c);
          end
        end
        default: begin
          from_idle(c);
        end
      endcase
      if (fresh.size() > 0) begin
        tok = fresh.pop_back();
        tok.last = 1'b1;
        fresh.push_back(tok);
      end
      foreach (fresh[i]) pending_tokens.push_back(fresh[i]);
      bytes_noted++;
    endfunction

    function void check_token(logic [2:0] kind, logic [TDATA_W-1:0] data, logic last);
      token_t want;
      if (pending_tokens.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("token with nothing expected: kind %0d data %h last %0b", kind, data, last);
        return;
      end
      want = pending_tokens.pop_front();
      if (kind !== want.kind || data[15:0] !== want.line || data[31:16] !== want.col ||
          data[39:32] !== want.len || data[71:40] !== want.value || data[72] !== want.oor ||
          data[TDATA_W-1:73] !== '0 || last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("token mismatch: expected kind %0d line %0d col %0d len %0d value %0d",
                   want.kind, want.line, want.col, want.len, $signed(want.value));
          $display("                expected oor %0b last %0b", want.oor, want.last);
          $display("                got      kind %0d line %0d col %0d len %0d value %0d",
                   kind, data[15:0], data[31:16], data[39:32], $signed(data[71:40]));
          $display("                got      oor %0b last %0b fill %h",
                   data[72], last, data[TDATA_W-1:73]);
        end
      end else begin
        seen[want.kind]++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [7:0]         s_axis_tdata_i = 8'h00;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata_o;
  logic [2:0]         m_axis_tuser_o;
  logic               m_axis_tlast_o;

  token_scoreboard sb;
  int              idle_pct = 0;
  int              stall_pct = 0;
  int              bytes_sent = 0;

  assembly_token_scanner dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) sb.note_byte(s_axis_tdata_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_token(m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_alpha();
    int r;
    r = int'($urandom_range(52));
    if (r < 26) return 8'(asc_pkg::CH_LOWER_A + r);
    else if (r < 52) return 8'(asc_pkg::CH_UPPER_A + r - 26);
    else return asc_pkg::CH_UNDERSCORE;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(asc_pkg::CH_ZERO + $urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_word_char();
    if ($urandom_range(62) < 53) return rand_alpha();
    else return rand_digit();
  endfunction

  task automatic send_word(input int tail);
    send_byte(rand_alpha());
    repeat (tail) send_byte(rand_word_char());
  endtask

  task automatic send_random_token();
    int         pick;
    int         n;
    logic [7:0] b;
    string      bound_vals[6] = '{"2147483647", "2147483648", "-2147483648", "-2147483649",
                                  "r2147483647", "r2147483648"};
    pick = int'($urandom_range(99));
    if (pick < 22) begin
      if ($urandom_range(19) == 0) begin
        send_str(bound_vals[$urandom_range(5)]);
      end else begin
        if ($urandom_range(9) < 3) send_byte(asc_pkg::CH_MINUS);
        n = int'(($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4));
        repeat (n) send_byte(rand_digit());
      end
    end else if (pick < 40) begin
      send_word(int'(($urandom_range(149) == 0) ? $urandom_range(255, 262)
                                                 : $urandom_range(0, 6)));
    end else if (pick < 55) begin
      send_byte(asc_pkg::CH_LOWER_R);
      n = int'(($urandom_range(7) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 3));
      repeat (n) send_byte(rand_digit());
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) send_byte(rand_word_char());
    end else if (pick < 65) begin
      if ($urandom_range(3) == 0) send_byte(asc_pkg::CH_LOWER_R);
      else send_byte(rand_alpha());
      repeat ($urandom_range(0, 5)) send_byte(rand_word_char());
      send_byte(asc_pkg::CH_COLON);
    end else if (pick < 70) begin
      send_byte(asc_pkg::CH_SEMI);
      repeat ($urandom_range(0, 8)) begin
        b = 8'($urandom_range(1, 255));
        send_byte((b == asc_pkg::CH_LF) ? asc_pkg::CH_SPACE : b);
      end
      send_byte(($urandom_range(4) == 0) ? asc_pkg::CH_NUL : asc_pkg::CH_LF);
    end else if (pick < 75) begin
      send_byte(asc_pkg::CH_MINUS);
    end else if (pick < 88) begin
      send_byte(8'($urandom_range(255)));
    end else begin
      send_byte(asc_pkg::CH_NUL);
    end
    pick = int'($urandom_range(9));
    if (pick < 2) return;
    else if (pick < 6) send_byte(asc_pkg::CH_SPACE);
    else if (pick == 6) send_byte(asc_pkg::CH_COMMA);
    else if (pick == 7) send_byte(asc_pkg::CH_LF);
    else if (pick == 8) send_byte(asc_pkg::CH_TAB);
    else send_byte(8'($urandom_range(asc_pkg::CH_TAB, asc_pkg::CH_CR)));
  endtask

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int target;
    int idle_set[4] = '{0, 82, 0, 28};
    int stall_set[4] = '{0, 0, 82, 28};
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every token kind, lone minus, comment cut by end of input, odd blanks and high bytes.
    send_str("r7 -12 L1: ;");
    send_byte(8'hFF);
    send_byte(asc_pkg::CH_NUL);
    send_str("-x");
    send_byte(8'h80);
    send_byte(asc_pkg::CH_COMMA);
    send_byte(8'h0B);
    send_str("_9");
    send_byte(8'h0C);
    send_byte(asc_pkg::CH_CR);
    send_byte(asc_pkg::CH_TAB);
    send_byte(8'h7F);
    send_byte(asc_pkg::CH_NUL);

    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_set[p];
      stall_pct = stall_set[p];
      target = bytes_sent + 140;
      while (bytes_sent < target) send_random_token();
    end

    // Close any open token so that every predicted token leaves the block.
    idle_pct = 0;
    stall_pct = 0;
    send_str("-5");
    send_byte(asc_pkg::CH_NUL);
    s_axis_tvalid_i <= 1'b0;

    while (sb.pending_tokens.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("%0d source bytes under four handshake settings, with long words and bound values.",
             sb.bytes_noted);
    $display("Matched: %0d int, %0d label, %0d reg, %0d ident, %0d illegal, %0d end.",
             sb.seen[asc_pkg::KIND_INT], sb.seen[asc_pkg::KIND_LABEL],
             sb.seen[asc_pkg::KIND_REG], sb.seen[asc_pkg::KIND_IDENT],
             sb.seen[asc_pkg::KIND_ILLEGAL], sb.seen[asc_pkg::KIND_END]);
    if (sb.errors == 0 && sb.pending_tokens.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
